// ===== rtl/token_scanner_with_positions_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the token scanner core.
// Each macro takes a label, clock, reset, antecedent and consequent.
// ---------------------------------------------------------------------------
`ifndef TOKEN_SCANNER_WITH_POSITIONS_CORE_ASSERT_SVH
`define TOKEN_SCANNER_WITH_POSITIONS_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define TSP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsp assertion failed");
// next-cycle implication
`define TSP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsp assertion failed");
`else
`define TSP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TSP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/tsp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsp_pkg
// Types, character codes and scan functions shared by the token scanner.
// ---------------------------------------------------------------------------
package tsp_pkg;

   localparam int LINE_BITS   = 16;
   localparam int OFFSET_BITS = 24;
   localparam int SLOTS       = 3;

   // scan modes
   localparam logic [2:0] MODE_START     = 3'd0;
   localparam logic [2:0] MODE_NORMAL    = 3'd1;
   localparam logic [2:0] MODE_INT       = 3'd2;
   localparam logic [2:0] MODE_LINE      = 3'd3;
   localparam logic [2:0] MODE_BLOCK     = 3'd4;
   localparam logic [2:0] MODE_BLOCK_END = 3'd5;

   // token kinds
   localparam logic [2:0] KIND_EOT     = 3'd0;
   localparam logic [2:0] KIND_PLUS    = 3'd1;
   localparam logic [2:0] KIND_SEMI    = 3'd2;
   localparam logic [2:0] KIND_INT     = 3'd3;
   localparam logic [2:0] KIND_INVALID = 3'd4;

   // character codes
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef struct packed {
      logic [7:0] byte_req;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [2:0]             kind;
      logic [LINE_BITS-1:0]   start_line;
      logic [LINE_BITS-1:0]   start_column;
      logic [OFFSET_BITS-1:0] start_offset;
      logic [OFFSET_BITS-1:0] line_start_offset;
      logic [OFFSET_BITS-1:0] end_offset;
      logic                   final_res;
   } rsp_type;

   typedef struct packed {
      logic [2:0]             mode;
      logic [7:0]             held;
      logic [LINE_BITS-1:0]   line;
      logic [LINE_BITS-1:0]   col;
      logic [OFFSET_BITS-1:0] off;
      logic [OFFSET_BITS-1:0] lbeg;
      logic [LINE_BITS-1:0]   tline;
      logic [LINE_BITS-1:0]   tcol;
      logic [OFFSET_BITS-1:0] toff;
      logic [OFFSET_BITS-1:0] tlbeg;
   } state_type;

   typedef struct packed {
      state_type st;
      logic      hit;
      rsp_type   rsp;
   } consume_type;

   function automatic state_type state_reset();
      state_type s;
      s       = '0;
      s.mode  = MODE_START;
      s.line  = LINE_BITS'(1);
      s.col   = LINE_BITS'(1);
      s.tline = LINE_BITS'(1);
      s.tcol  = LINE_BITS'(1);
      return s;
   endfunction

   function automatic logic [LINE_BITS-1:0] sat_line(logic [LINE_BITS-1:0] v);
      return (v == {LINE_BITS{1'b1}}) ? v : v + LINE_BITS'(1);
   endfunction

   function automatic logic [OFFSET_BITS-1:0] sat_off(logic [OFFSET_BITS-1:0] v);
      return (v == {OFFSET_BITS{1'b1}}) ? v : v + OFFSET_BITS'(1);
   endfunction

   function automatic logic is_dig(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic rsp_type make_rsp(logic [2:0] kind, logic [LINE_BITS-1:0] sl,
                                        logic [LINE_BITS-1:0] sc,
                                        logic [OFFSET_BITS-1:0] so,
                                        logic [OFFSET_BITS-1:0] lb,
                                        logic [OFFSET_BITS-1:0] eo);
      rsp_type r;
      r.kind              = kind;
      r.start_line        = sl;
      r.start_column      = sc;
      r.start_offset      = so;
      r.line_start_offset = lb;
      r.end_offset        = eo;
      r.final_res         = 1'b0;
      return r;
   endfunction

   // step position past one byte
   function automatic state_type advance(state_type s, logic nl);
      state_type o;
      o = s;
      if (nl) begin
         o.line = sat_line(s.line);
         o.col  = LINE_BITS'(1);
         o.lbeg = sat_off(s.off);
      end else begin
         o.col = sat_line(s.col);
      end
      o.off = sat_off(s.off);
      return o;
   endfunction

   // classify byte c with lookahead n (nv: lookahead present)
   function automatic consume_type consume(state_type s, logic [7:0] c, logic [7:0] n,
                                           logic nv);
      consume_type o;
      logic        more;
      logic        nl;
      logic        ws;
      o.st   = s;
      o.hit  = 1'b0;
      o.rsp  = '0;
      more   = nv && is_dig(n);
      nl     = (c == CH_LF);
      ws     = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || nl;
      case (s.mode)
         MODE_INT: begin
            if (!more) begin
               o.hit     = 1'b1;
               o.rsp     = make_rsp(KIND_INT, s.tline, s.tcol, s.toff, s.tlbeg,
                                    sat_off(s.off));
               o.st.mode = MODE_NORMAL;
            end
            o.st = advance(o.st, 1'b0);
         end
         MODE_LINE: begin
            if (nl) o.st.mode = MODE_NORMAL;
            o.st = advance(o.st, nl);
         end
         MODE_BLOCK: begin
            if ((c == CH_STAR) && nv && (n == CH_SLASH)) o.st.mode = MODE_BLOCK_END;
            o.st = advance(o.st, nl);
         end
         MODE_BLOCK_END: begin
            o.st.mode = MODE_NORMAL;
            o.st      = advance(o.st, nl);
         end
         default: begin
            o.st.mode = MODE_NORMAL;
            if (ws) begin
               o.st = advance(o.st, nl);
            end else if ((c == CH_SLASH) && nv && (n == CH_SLASH)) begin
               o.st.mode = MODE_LINE;
               o.st      = advance(o.st, 1'b0);
            end else if ((c == CH_SLASH) && nv && (n == CH_STAR)) begin
               o.st.mode = MODE_BLOCK;
               o.st      = advance(o.st, 1'b0);
            end else if (is_dig(c) && more) begin
               o.st.tline = s.line;
               o.st.tcol  = s.col;
               o.st.toff  = s.off;
               o.st.tlbeg = s.lbeg;
               o.st.mode  = MODE_INT;
               o.st       = advance(o.st, 1'b0);
            end else begin
               o.hit = 1'b1;
               o.rsp = make_rsp((c == CH_PLUS) ? KIND_PLUS :
                                (c == CH_SEMI) ? KIND_SEMI :
                                is_dig(c)      ? KIND_INT : KIND_INVALID,
                                s.line, s.col, s.off, s.lbeg, sat_off(s.off));
               o.st  = advance(o.st, 1'b0);
            end
         end
      endcase
      return o;
   endfunction

endpackage

// ===== rtl/token_scanner_with_positions_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// token_scanner_with_positions_core
// Streaming scanner: source bytes in, positioned tokens out.
// ---------------------------------------------------------------------------
// Usage:
//   req_ carries one source byte per word, with last on the final byte.
//   rsp_ carries one token per word: kind, start line/column/offset,
//   line start offset, end offset, and final_res on the last token that
//   an input word caused. The last byte of a text always yields the
//   end-of-text token, after which the scanner is back in its reset state.
//   Each input word is scanned in the cycle it is accepted; its tokens
//   (zero to three) sit in a three-entry result buffer and appear on rsp_
//   from the next cycle, one per cycle while rsp_stall is low.
//   Throughput is one byte per cycle while each byte yields at most one
//   token and rsp_ does not stall; a word yielding more tokens holds
//   req_stall until the last of its tokens leaves the single result buffer.
//   A stalled rsp_ word holds; req_stall rises once the buffer cannot take
//   the next word's tokens. Reset empties the buffer and clears the
//   scanner position to line 1, column 1, offset 0.
// ---------------------------------------------------------------------------
`include "token_scanner_with_positions_core_assert.svh"

module token_scanner_with_positions_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tsp_pkg::req_type  req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tsp_pkg::rsp_type  rsp
);

   tsp_pkg::state_type state_ff;
   tsp_pkg::state_type state_in;
   tsp_pkg::rsp_type   slot_ff [tsp_pkg::SLOTS];
   tsp_pkg::rsp_type   slot_in [tsp_pkg::SLOTS];
   logic [1:0]         rd_ff;
   logic [1:0]         cnt_ff;
   logic [1:0]         cnt_in;
   logic               take;
   logic               accept;

   tsp_step u_step (
      .st      (state_ff),
      .req     (req),
      .st_next (state_in),
      .slot    (slot_in),
      .count   (cnt_in)
   );

   // handshake: take a new word once the buffer is empty or its last token is being taken
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp       = slot_ff[rd_ff];
   assign take      = rsp_valid && !rsp_stall;
   assign req_stall = !((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && take));
   assign accept    = req_valid && !req_stall;

   // advance scanner state and buffer pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsp_pkg::state_reset();
         rd_ff    <= 2'd0;
         cnt_ff   <= 2'd0;
      end else if (accept) begin
         state_ff <= state_in;
         rd_ff    <= 2'd0;
         cnt_ff   <= cnt_in;
      end else if (take) begin
         rd_ff  <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   // load token payloads
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < tsp_pkg::SLOTS; i++) slot_ff[i] <= slot_in[i];
      end
   end

   `TSP_ASSERT_IMP(a_buf_bound, clock, reset, 1'b1, ({1'b0, rd_ff} + {1'b0, cnt_ff}) <= 3'd3)
   `TSP_ASSERT_IMP(a_final_last, clock, reset, rsp_valid, rsp.final_res == (cnt_ff == 2'd1))
   `TSP_ASSERT_IMP(a_eot_final, clock, reset, rsp_valid && (rsp.kind == tsp_pkg::KIND_EOT), rsp.final_res)
   `TSP_ASSERT_NXT(a_last_emits, clock, reset, accept && req.last, rsp_valid && (rd_ff == 2'd0))

endmodule

// ===== rtl/tsp_step.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsp_step
// Scan logic for one input byte: next scanner state and up to three tokens.
// ---------------------------------------------------------------------------
module tsp_step (
   input  tsp_pkg::state_type st,
   input  tsp_pkg::req_type   req,
   output tsp_pkg::state_type st_next,
   output tsp_pkg::rsp_type   slot [tsp_pkg::SLOTS],
   output logic [1:0]         count
);

   tsp_pkg::consume_type c1;
   tsp_pkg::consume_type c2;
   tsp_pkg::state_type   s1;
   tsp_pkg::rsp_type     eot;
   logic                 hit1;
   logic [1:0]           n;

   // consume the held byte with the new byte as lookahead
   always_comb begin
      c1   = tsp_pkg::consume(st, st.held, req.byte_req, 1'b1);
      hit1 = (st.mode != tsp_pkg::MODE_START) && c1.hit;
      if (st.mode == tsp_pkg::MODE_START) begin
         s1      = st;
         s1.mode = tsp_pkg::MODE_NORMAL;
      end else begin
         s1 = c1.st;
      end
      s1.held = req.byte_req;
   end

   // on the last byte, flush it without lookahead and close the text
   always_comb begin
      c2  = tsp_pkg::consume(s1, req.byte_req, 8'h00, 1'b0);
      eot = tsp_pkg::make_rsp(tsp_pkg::KIND_EOT, c2.st.line, c2.st.col, c2.st.off,
                              c2.st.lbeg, c2.st.off);
      st_next = req.last ? tsp_pkg::state_reset() : s1;
   end

   // pack tokens in order and flag the last one
   always_comb begin
      n = 2'd0;
      for (int i = 0; i < tsp_pkg::SLOTS; i++) slot[i] = '0;
      if (hit1) begin
         slot[n] = c1.rsp;
         n       = n + 2'd1;
      end
      if (req.last) begin
         if (c2.hit) begin
            slot[n] = c2.rsp;
            n       = n + 2'd1;
         end
         slot[n] = eot;
         n       = n + 2'd1;
      end
      if (n != 2'd0) slot[n - 2'd1].final_res = 1'b1;
      count = n;
   end

endmodule
